>>> hdl/fcgi_pkg.sv
package fcgi_pkg;

  localparam int ByteW  = 8;
  localparam int KindW  = 2;
  localparam int PhaseW = 2;
  localparam int CountW = 3;
  localparam int LenW   = 16;

  localparam logic [PhaseW-1:0] PH_HEADER  = 2'd0;
  localparam logic [PhaseW-1:0] PH_CONTENT = 2'd1;
  localparam logic [PhaseW-1:0] PH_PADDING = 2'd2;
  localparam logic [PhaseW-1:0] PH_ENDED   = 2'd3;

  localparam logic [ByteW-1:0] TYPE_ABORT = 8'd2;
  localparam logic [ByteW-1:0] TYPE_END   = 8'd3;

  localparam logic [CountW-1:0] HDR_TYPE   = 3'd1;
  localparam logic [CountW-1:0] HDR_LEN_HI = 3'd4;
  localparam logic [CountW-1:0] HDR_LEN_LO = 3'd5;
  localparam logic [CountW-1:0] HDR_PAD    = 3'd6;
  localparam logic [CountW-1:0] HDR_LAST   = 3'd7;

  localparam logic [KindW-1:0] KIND_CONTENT = 2'd0;
  localparam logic [KindW-1:0] KIND_END     = 2'd1;
  localparam logic [KindW-1:0] KIND_ABORT   = 2'd2;
  localparam logic [KindW-1:0] KIND_AFTER   = 2'd3;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] record_kind;
    logic             last_in_record;
  } result_t;

endpackage

>>> hdl/fastcgi_record_deframer_top.sv
// FastCGI record deframer.
// The s_axis channel takes the raw response stream, one byte per word in
// s_axis_tdata. The m_axis channel returns one word for each content byte
// and one word for each event: m_axis_tuser gives the kind (content byte,
// end request, abort, byte after end), m_axis_tdata carries the content
// byte and the type of the current record, and m_axis_tlast marks the
// final content byte of a record. Header and padding bytes give no word.
// Each word is registered in the output or skid entry as its byte is taken.
// The block accepts one byte every cycle while s_axis_tready is high; the
// header capture and length counters are updated in the same cycle it is taken.
// A two-entry output register (main plus skid) lets a byte be accepted
// while a result still waits, so s_axis_tready falls only when both
// entries are full under a stalled receiver.
// After an end request or abort header every further byte is reported as
// a byte after the end until reset. Reset (rst, synchronous, active high)
// returns the parser to the start of a header and empties the output.
module fastcgi_record_deframer_top
  import fcgi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ByteW-1:0]     s_axis_tdata,   // [7:0] data_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*ByteW-1:0]   m_axis_tdata,   // [7:0] payload_byte, [15:8] record_kind
  output logic [KindW-1:0]     m_axis_tuser,   // [1:0] kind
  output logic                 m_axis_tlast    // last_in_record
);

  logic [PhaseW-1:0] phase, phase_next;
  logic [CountW-1:0] header_count, header_count_next;
  logic [ByteW-1:0]  current_type, current_type_next;
  logic [LenW-1:0]   content_left, content_left_next;
  logic [ByteW-1:0]  padding_left, padding_left_next;
  logic [ByteW-1:0]  length_high, length_high_next;

  logic    res_valid;
  result_t res;

  logic    out_valid, skid_valid;
  result_t out_reg, skid_reg;
  logic    in_acc, out_acc;

  assign s_axis_tready = !skid_valid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_valid && m_axis_tready;

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    current_type_next = current_type;
    content_left_next = content_left;
    padding_left_next = padding_left;
    length_high_next  = length_high;
    res_valid         = 1'b0;
    res               = '0;
    unique case (phase)
      PH_HEADER: begin
        unique case (header_count)
          HDR_TYPE:   current_type_next = s_axis_tdata;
          HDR_LEN_HI: length_high_next  = s_axis_tdata;
          HDR_LEN_LO: content_left_next = {length_high, s_axis_tdata};
          HDR_PAD:    padding_left_next = s_axis_tdata;
          default:    ;
        endcase
        header_count_next = header_count + 1'b1;
        if (header_count == HDR_LAST) begin
          if (current_type == TYPE_END || current_type == TYPE_ABORT) begin
            phase_next       = PH_ENDED;
            res_valid        = 1'b1;
            res.kind         = (current_type == TYPE_END) ? KIND_END : KIND_ABORT;
            res.record_kind  = current_type;
          end else if (content_left != '0) begin
            phase_next = PH_CONTENT;
          end else if (padding_left != '0) begin
            phase_next = PH_PADDING;
          end
        end
      end
      PH_CONTENT: begin
        res_valid          = 1'b1;
        res.kind           = KIND_CONTENT;
        res.payload_byte   = s_axis_tdata;
        res.record_kind    = current_type;
        res.last_in_record = (content_left <= LenW'(1));
        if (content_left != '0) begin
          content_left_next = content_left - 1'b1;
        end
        if (content_left <= LenW'(1)) begin
          phase_next = (padding_left != '0) ? PH_PADDING : PH_HEADER;
        end
      end
      PH_PADDING: begin
        if (padding_left != '0) begin
          padding_left_next = padding_left - 1'b1;
        end
        if (padding_left <= ByteW'(1)) begin
          phase_next = PH_HEADER;
        end
      end
      PH_ENDED: begin
        res_valid       = 1'b1;
        res.kind        = KIND_AFTER;
        res.record_kind = current_type;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      current_type <= '0;
      content_left <= '0;
      padding_left <= '0;
      length_high  <= '0;
    end else if (in_acc) begin
      phase        <= phase_next;
      header_count <= header_count_next;
      current_type <= current_type_next;
      content_left <= content_left_next;
      padding_left <= padding_left_next;
      length_high  <= length_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_acc && res_valid && (!out_valid || out_acc)) begin
        out_valid <= 1'b1;
        out_reg   <= res;
      end else if (out_acc) begin
        out_valid <= skid_valid;
        out_reg   <= skid_reg;
      end
      if (in_acc && res_valid && out_valid && !out_acc) begin
        skid_valid <= 1'b1;
        skid_reg   <= res;
      end else if (out_acc) begin
        skid_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_reg.record_kind, out_reg.payload_byte};
  assign m_axis_tuser  = out_reg.kind;
  assign m_axis_tlast  = out_reg.last_in_record;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a word while the output entry is empty");

  a_ended_sticks: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ENDED |=> phase == PH_ENDED)
    else $error("parser left the ended phase without reset");

  a_count_in_header: assert property (@(posedge clk) disable iff (rst)
    header_count != '0 |-> phase == PH_HEADER)
    else $error("partial header count outside the header phase");

  a_last_is_content: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIND_CONTENT)
    else $error("last marker on a word that is not a content byte");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PADDING |-> padding_left != '0)
    else $error("padding phase with no padding left");

endmodule
